[sv/adagrad_element_update_macros.svh]
// assertion macros for the adagrad element update block
// used by the top level only; no other dependencies
`ifndef ADAGRAD_ELEMENT_UPDATE_MACROS_SVH
`define ADAGRAD_ELEMENT_UPDATE_MACROS_SVH
`ifndef SYNTHESIS
`define ADG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("adagrad element update: assertion failed");
`define ADG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adagrad element update: assertion failed");
`else
`define ADG_ASSERT(label, clk, rst_n, prop)
`define ADG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/adg_pkg.sv]
// shared types and constants for the adagrad element update block
// no dependencies
package adg_pkg;

    localparam logic ACT_UPDATE   = 1'b0;
    localparam logic ACT_ROLLBACK = 1'b1;

    localparam logic CFG_LEARNING_RATE    = 1'b0;
    localparam logic CFG_STABILITY_OFFSET = 1'b1;

    localparam logic [31:0] ETA_RESET = 32'd6554;
    localparam logic [47:0] EPS_RESET = 48'd1;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 33;

    // per-item sideband that rides along the arithmetic pipeline
    typedef struct packed {
        logic        action;
        logic [9:0]  idx;
        logic        gneg;
        logic [31:0] point;
        logic        sat_acc;
        logic        bypass;
    } t_side;

endpackage

[sv/adg_sqrt_pipe.sv]
// pipelined integer square root, one result bit per stage
// depends on adg_pkg
module adg_sqrt_pipe import adg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_side       i_side,
    input  logic [63:0] i_num,
    input  logic [62:0] i_rad,
    output logic        o_valid,
    output t_side       o_side,
    output logic [63:0] o_num,
    output logic [31:0] o_root
);

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } t_sq_st;

    function automatic t_sq_st sq_step(input t_sq_st s);
        t_sq_st      t;
        logic [35:0] r2;
        logic [35:0] trial;
        r2    = {s.rem, s.rad[63:62]};
        trial = {2'b00, s.root, 2'b01};
        t.rad = {s.rad[61:0], 2'b00};
        if (r2 >= trial) begin
            t.rem  = 34'(r2 - trial);
            t.root = {s.root[30:0], 1'b1};
        end else begin
            t.rem  = r2[33:0];
            t.root = {s.root[30:0], 1'b0};
        end
        return t;
    endfunction

    t_sq_st                r_st   [0:SQRT_STEPS-1];
    t_sq_st                n_st   [0:SQRT_STEPS-1];
    t_side                 r_side [0:SQRT_STEPS-1];
    logic [63:0]           r_num  [0:SQRT_STEPS-1];
    logic [SQRT_STEPS-1:0] r_vld;
    t_sq_st                init_st;

    always_comb begin
        init_st.rem  = '0;
        init_st.root = '0;
        init_st.rad  = {1'b0, i_rad};
        n_st[0] = sq_step(init_st);
        for (int k = 1; k < SQRT_STEPS; k++) begin
            n_st[k] = sq_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQRT_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st      <= n_st;
            r_side[0] <= i_side;
            r_num[0]  <= i_num;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
                r_num[k]  <= r_num[k-1];
            end
        end
    end

    assign o_valid = r_vld[SQRT_STEPS-1];
    assign o_side  = r_side[SQRT_STEPS-1];
    assign o_num   = r_num[SQRT_STEPS-1];
    assign o_root  = r_st[SQRT_STEPS-1].root;

endmodule

[sv/adg_div_pipe.sv]
// pipelined restoring divider, 33 quotient bits, one bit per stage
// flags quotients of 2^33 and above; depends on adg_pkg
module adg_div_pipe import adg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_side       i_side,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_valid,
    output t_side       o_side,
    output logic [32:0] o_quot,
    output logic        o_big
);

    typedef struct packed {
        logic [32:0] rem;
        logic [32:0] quot;
        logic [32:0] num;
        logic [32:0] den;
    } t_dv_st;

    function automatic t_dv_st dv_step(input t_dv_st s);
        t_dv_st      t;
        logic [33:0] r2;
        r2    = {s.rem, s.num[32]};
        t.num = {s.num[31:0], 1'b0};
        t.den = s.den;
        if (r2 >= {1'b0, s.den}) begin
            t.rem  = 33'(r2 - {1'b0, s.den});
            t.quot = {s.quot[31:0], 1'b1};
        end else begin
            t.rem  = r2[32:0];
            t.quot = {s.quot[31:0], 1'b0};
        end
        return t;
    endfunction

    t_dv_st               r_st   [0:DIV_STEPS-1];
    t_dv_st               n_st   [0:DIV_STEPS-1];
    t_side                r_side [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] r_big;
    logic [DIV_STEPS-1:0] r_vld;
    t_dv_st               init_st;
    logic                 big;

    // quotient overflows 33 bits when the top numerator bits reach the divisor
    assign big = {2'b00, i_num[63:33]} >= i_den;

    always_comb begin
        init_st.rem  = {2'b00, i_num[63:33]};
        init_st.quot = '0;
        init_st.num  = i_num[32:0];
        init_st.den  = i_den;
        n_st[0] = dv_step(init_st);
        for (int k = 1; k < DIV_STEPS; k++) begin
            n_st[k] = dv_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st      <= n_st;
            r_big     <= {r_big[DIV_STEPS-2:0], big};
            r_side[0] <= i_side;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[DIV_STEPS-1];
    assign o_side  = r_side[DIV_STEPS-1];
    assign o_quot  = r_st[DIV_STEPS-1].quot;
    assign o_big   = r_big[DIV_STEPS-1];

endmodule

[sv/adagrad_element_update.sv]
// adagrad element update top level: accumulator store, front stages,
// output stage; depends on adg_pkg, adg_sqrt_pipe, adg_div_pipe
//
// Usage:
//  input channel (i_in_valid / o_in_stall) takes one element per transfer:
//  action, element index, gradient and point, all Q16.16.
//  output channel (o_out_valid / i_out_stall) returns the element index,
//  the new point and a saturation flag, one result per input, in order.
//  config channel (i_cfg_valid / o_cfg_ready, always ready) writes
//  learning_rate (index 0) and stability_offset (index 1); the user must
//  write them only while idle, the block does not enforce it. Throughput
//  is one element per cycle unless the output stalls or the memory clears.
//  Inputs pass 3 front stages (read/square, accumulate and write back,
//  scale), 32 square root and 33 divider stages and the output register.
//  The per-element sums sit in a NUM_ELEMENTS x 48 memory with one write
//  and one registered read port; back to back hits on the same element
//  are forwarded from the write back stage.
//  After reset the memory is zeroed one entry a cycle, with o_in_stall
//  high; config writes are still taken.
//  When the receiver stalls a valid output, the whole pipeline holds and o_in_stall rises.
`include "adagrad_element_update_macros.svh"
module adagrad_element_update import adg_pkg::*; #(
    parameter int NUM_ELEMENTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic [9:0]         i_element_index,
    input  logic signed [31:0] i_gradient_value,
    input  logic signed [31:0] i_point_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [9:0]         o_element_echo,
    output logic signed [31:0] o_new_point_value,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [47:0]        i_cfg_data
);

    localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

    logic [31:0] r_eta;
    logic [47:0] r_eps;

    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    logic [47:0]   r_mem [0:NUM_ELEMENTS-1];
    logic [47:0]   r_rd;
    logic          r_fwd;
    logic [47:0]   r_fwd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [47:0]   mem_wdata;

    logic adv;
    logic accept;

    logic [31:0] in_gmag;
    logic        in_gneg;
    logic        in_range;
    t_side       in_side;

    logic        r1_valid;
    t_side       r1_side;
    logic [31:0] r1_gmag;
    logic [47:0] r1_sq;

    logic [47:0] s1_cur;
    logic [48:0] s1_sum;
    logic        s1_upd;
    logic [47:0] s1_new;
    logic        s1_we;
    t_side       s1_side;

    logic        r2_valid;
    t_side       r2_side;
    logic [47:0] r2_sum;
    logic [63:0] r2_num;

    logic [48:0] s2_scale;
    t_side       s2_side;

    logic        r3_valid;
    t_side       r3_side;
    logic [63:0] r3_num;
    logic [62:0] r3_rad;

    logic        sq_valid;
    t_side       sq_side;
    logic [63:0] sq_num;
    logic [31:0] sq_root;

    logic        dv_valid;
    t_side       dv_side;
    logic [32:0] dv_quot;
    logic        dv_big;

    logic               fin_sub;
    logic signed [34:0] fin_res;
    logic signed [31:0] fin_point;
    logic               fin_sat;

    logic        r_out_valid;
    logic [9:0]  r_out_idx;
    logic [31:0] r_out_point;
    logic        r_out_sat;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta <= ETA_RESET;
            r_eps <= EPS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEARNING_RATE:    r_eta <= i_cfg_data[31:0];
                CFG_STABILITY_OFFSET: r_eps <= i_cfg_data;
                default:              r_eta <= r_eta;
            endcase
        end
    end

    // pipeline control: everything moves together
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = !adv || r_clearing;
    assign accept     = i_in_valid && !o_in_stall;

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(NUM_ELEMENTS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // input decode
    assign in_gneg  = i_gradient_value[31];
    assign in_gmag  = in_gneg ? 32'(-i_gradient_value) : i_gradient_value;
    assign in_range = {22'd0, i_element_index} < 32'(NUM_ELEMENTS);

    always_comb begin
        in_side.action  = i_action;
        in_side.idx     = i_element_index;
        in_side.gneg    = in_gneg;
        in_side.point   = i_point_value;
        in_side.sat_acc = 1'b0;
        in_side.bypass  = !in_range;
    end

    // accumulator memory
    assign mem_we    = r_clearing || s1_we;
    assign mem_waddr = r_clearing ? r_clr_addr : AW'(r1_side.idx);
    assign mem_wdata = r_clearing ? 48'd0 : s1_new;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (adv) begin
            r_rd <= r_mem[AW'(i_element_index)];
        end
    end

    // same element written back while the next one reads it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (adv) begin
            r_fwd <= s1_we && (r1_side.idx == i_element_index);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fwd_data <= s1_new;
        end
    end

    // stage 1: square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_side <= in_side;
            r1_gmag <= in_gmag;
            r1_sq   <= 48'((64'(in_gmag) * 64'(in_gmag)) >> 16);
        end
    end

    // stage 2: accumulate, saturate, write back
    assign s1_cur = r_fwd ? r_fwd_data : r_rd;
    assign s1_sum = {1'b0, s1_cur} + {1'b0, r1_sq};
    assign s1_upd = (r1_side.action == ACT_UPDATE) && !r1_side.bypass;
    assign s1_new = s1_sum[48] ? '1 : s1_sum[47:0];
    assign s1_we  = adv && r1_valid && s1_upd;

    always_comb begin
        s1_side         = r1_side;
        s1_side.sat_acc = s1_upd && s1_sum[48];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_side <= s1_side;
            r2_sum  <= s1_upd ? s1_new : s1_cur;
            r2_num  <= 64'(r_eta) * 64'(r1_gmag);
        end
    end

    // stage 3: scale
    assign s2_scale = {1'b0, r_eps} + {1'b0, r2_sum};

    always_comb begin
        s2_side        = r2_side;
        s2_side.bypass = r2_side.bypass || (s2_scale == 49'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (adv) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_side <= s2_side;
            r3_num  <= r2_num;
            r3_rad  <= {s2_scale, 14'd0};
        end
    end

    adg_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r3_valid),
        .i_side  (r3_side),
        .i_num   (r3_num),
        .i_rad   (r3_rad),
        .o_valid (sq_valid),
        .o_side  (sq_side),
        .o_num   (sq_num),
        .o_root  (sq_root)
    );

    adg_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (sq_valid),
        .i_side  (sq_side),
        .i_num   (sq_num),
        .i_den   ({sq_root, 1'b0}),
        .o_valid (dv_valid),
        .o_side  (dv_side),
        .o_quot  (dv_quot),
        .o_big   (dv_big)
    );

    // apply step and clamp
    assign fin_sub = (dv_side.action == ACT_UPDATE) != dv_side.gneg;
    assign fin_res = fin_sub
        ? 35'(signed'(dv_side.point)) - signed'({2'b00, dv_quot})
        : 35'(signed'(dv_side.point)) + signed'({2'b00, dv_quot});

    always_comb begin
        fin_point = dv_side.point;
        fin_sat   = dv_side.sat_acc;
        if (!dv_side.bypass) begin
            if (dv_big) begin
                fin_point = fin_sub ? 32'sh8000_0000 : 32'sh7fff_ffff;
                fin_sat   = 1'b1;
            end else if (fin_res > 35'sd2147483647) begin
                fin_point = 32'sh7fff_ffff;
                fin_sat   = 1'b1;
            end else if (fin_res < -35'sd2147483648) begin
                fin_point = 32'sh8000_0000;
                fin_sat   = 1'b1;
            end else begin
                fin_point = fin_res[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_idx   <= dv_side.idx;
            r_out_point <= fin_point;
            r_out_sat   <= fin_sat;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_element_echo    = r_out_idx;
    assign o_new_point_value = r_out_point;
    assign o_saturated       = r_out_sat;

    `ADG_ASSERT(a_no_wb_in_stall, i_clk, i_rst_n, (r_out_valid && i_out_stall) |-> !s1_we)
    `ADG_ASSERT(a_empty_in_clear, i_clk, i_rst_n, r_clearing |-> !r1_valid && !r2_valid)
    `ADG_ASSERT_NEXT(a_fwd_from_wb, i_clk, i_rst_n, !s1_we && adv, !r_fwd)

endmodule

[tb/sv/adagrad_element_update_test.sv]
// testbench for the adagrad element update block: directed and random
// elements, with a predictor of the accumulator store; depends on adg_pkg
`timescale 1ns / 100ps
module adagrad_element_update_test;
    import adg_pkg::*;

    typedef struct {
        logic [9:0]  idx;
        logic [31:0] point;
        logic        sat;
    } t_point_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_action = ACT_UPDATE;
    logic [9:0]         i_element_index = '0;
    logic signed [31:0] i_gradient_value = '0;
    logic signed [31:0] i_point_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [9:0]         o_element_echo;
    logic signed [31:0] o_new_point_value;
    logic               o_saturated;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = CFG_LEARNING_RATE;
    logic [47:0]        i_cfg_data = '0;

    logic [31:0] eta_model;
    logic [47:0] eps_model;
    logic [47:0] sum_model [1024];
    t_point_result expected_points [$];
    int mismatches = 0;
    bit rx_random = 1'b0;
    int rx_hold = 0;
    int rx_wait = 0;

    adagrad_element_update u_dut (.*);

    always #4 i_clk = ~i_clk;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic t_point_result predict_step(logic act, logic [9:0] idx,
                                                   logic [31:0] g, logic [31:0] p);
        t_point_result r;
        logic [63:0] gmag;
        logic [63:0] sum;
        logic [63:0] scale;
        logic [63:0] root;
        logic [63:0] q;
        longint res;
        gmag = g[31] ? {32'd0, -g} : {32'd0, g};
        res = longint'(signed'(p));
        r.idx = idx;
        r.sat = 1'b0;
        sum = {16'd0, sum_model[idx]};
        if (act == ACT_UPDATE) begin
            sum = sum + ((gmag * gmag) >> 16);
            if (sum > 64'hFFFF_FFFF_FFFF) begin
                sum = 64'hFFFF_FFFF_FFFF;
                r.sat = 1'b1;
            end
            sum_model[idx] = sum[47:0];
        end
        scale = {16'd0, eps_model} + sum;
        if (scale != 0) begin
            root = int_sqrt(scale << 14);
            q = ({32'd0, eta_model} * gmag) / (2 * root);
            // against the gradient on update, along it on rollback
            if ((act == ACT_UPDATE) != g[31]) res = res - longint'(q);
            else res = res + longint'(q);
            if (res > 64'sd2147483647) begin
                res = 64'sd2147483647;
                r.sat = 1'b1;
            end else if (res < -64'sd2147483648) begin
                res = -64'sd2147483648;
                r.sat = 1'b1;
            end
        end
        r.point = res[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        mismatches++;
    endtask

    // called at a falling edge; valid stays high after a transfer until
    // the next item or a drain decides otherwise
    task automatic send_element(logic act, logic [9:0] idx, logic [31:0] g,
                                logic [31:0] p, bit gaps = 1'b1);
        int gap;
        gap = gaps ? $urandom_range(0, 6) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_element_index <= idx;
        i_gradient_value <= g;
        i_point_value <= p;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_points.push_back(predict_step(act, idx, g, p));
        @(negedge i_clk);
    endtask

    task automatic write_register(logic index, logic [47:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (index == CFG_LEARNING_RATE) eta_model = value[31:0];
        else eps_model = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // receiver: a random wait drawn per result, plus an optional long hold-off
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_out_stall <= 1'b1;
            rx_hold <= rx_hold - 1;
        end else if (rx_random) begin
            if (rx_wait > 0) begin
                i_out_stall <= 1'b1;
                rx_wait <= rx_wait - 1;
            end else begin
                i_out_stall <= 1'b0;
                if (o_out_valid) rx_wait <= $urandom_range(0, 6);
            end
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_point_result w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected result", o_element_echo, 0);
            end else begin
                w = expected_points.pop_front();
                if (o_element_echo !== w.idx)
                    report_mismatch("element_echo", o_element_echo, w.idx);
                if (o_new_point_value !== w.point)
                    report_mismatch("new_point_value", o_new_point_value, w.point);
                if (o_saturated !== w.sat)
                    report_mismatch("saturated", o_saturated, w.sat);
            end
        end
    end

    task automatic test_directed;
        send_element(ACT_UPDATE, 10'd0, 32'h0001_0000, 32'h0001_0000);
        send_element(ACT_UPDATE, 10'd0, 32'hFFFF_0000, 32'h0000_0000);
        send_element(ACT_ROLLBACK, 10'd0, 32'h0001_0000, 32'h0000_0000);
        send_element(ACT_ROLLBACK, 10'd1, 32'h0000_0001, 32'h1234_5678);
        send_element(ACT_UPDATE, 10'd1023, 32'h7FFF_FFFF, 32'h8000_0000);
        send_element(ACT_UPDATE, 10'd1022, 32'h8000_0000, 32'h7FFF_FFFF);
        send_element(ACT_ROLLBACK, 10'd1022, 32'h8000_0000, 32'h7FFF_FFFF);
        send_element(ACT_UPDATE, 10'd5, 32'h0000_0000, 32'hFFFF_FFFF);
        // same element back to back
        for (int k = 0; k < 6; k++)
            send_element(ACT_UPDATE, 10'd7, 32'h0100_0000, 32'h0, 1'b0);
        drain();
    endtask

    task automatic test_zero_scale;
        write_register(CFG_STABILITY_OFFSET, 48'd0);
        send_element(ACT_ROLLBACK, 10'd300, 32'h0004_0000, 32'hDEAD_BEEF);
        send_element(ACT_UPDATE, 10'd301, 32'h0000_0000, 32'h0BAD_F00D);
        send_element(ACT_UPDATE, 10'd302, 32'h0000_00FF, 32'h0000_1000);
        drain();
    endtask

    task automatic test_accumulator_clamp;
        write_register(CFG_STABILITY_OFFSET, 48'hFFFF_FFFF_FFFF);
        write_register(CFG_LEARNING_RATE, 32'hFFFF_FFFF);
        for (int k = 0; k < 6; k++)
            send_element(ACT_UPDATE, 10'd900, 32'h8000_0000, 32'h7FFF_FFFF);
        send_element(ACT_ROLLBACK, 10'd900, 32'h7FFF_FFFF, 32'h8000_0000);
        drain();
    endtask

    task automatic test_random(int count);
        logic [31:0] g;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 3))
                0: g = $urandom;
                1: g = $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
                2: g = {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
                default: g = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            endcase
            send_element(($urandom_range(0, 3) == 0) ? ACT_ROLLBACK : ACT_UPDATE,
                         ($urandom_range(0, 1) ? 10'($urandom_range(0, 15)) : 10'($urandom)),
                         g, $urandom);
        end
        drain();
    endtask

    task automatic test_backpressure;
        rx_hold = 120;
        for (int k = 0; k < 150; k++)
            send_element(1'($urandom_range(0, 1)), 10'($urandom_range(0, 31)),
                         $urandom, $urandom, 1'b0);
        drain();
    endtask

    initial begin
        eta_model = ETA_RESET;
        eps_model = EPS_RESET;
        foreach (sum_model[k]) sum_model[k] = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_zero_scale();
        test_accumulator_clamp();
        write_register(CFG_LEARNING_RATE, 32'd0);
        write_register(CFG_STABILITY_OFFSET, 48'd1);
        test_random(100);
        write_register(CFG_LEARNING_RATE, 32'd6554);
        rx_random = 1'b1;
        test_random(500);
        write_register(CFG_LEARNING_RATE, 32'h0010_0000);
        write_register(CFG_STABILITY_OFFSET, 48'h0000_0001_0000);
        test_random(500);
        rx_random = 1'b0;
        test_backpressure();
        rx_random = 1'b1;
        write_register(CFG_LEARNING_RATE, $urandom);
        write_register(CFG_STABILITY_OFFSET, {$urandom, 16'($urandom)});
        test_random(350);
        if (mismatches == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
